// File: hw/rtl/tdpt_pkg.sv
`default_nettype none

package tdpt_pkg;

  // widths of the tested number, the input port and the divisor count
  localparam int NUM_WIDTH   = 16;
  localparam int IN_WIDTH    = 16;
  localparam int COUNT_WIDTH = 8;
  localparam int BIT_CNT_W   = $clog2(NUM_WIDTH);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = '1;
  localparam logic [COUNT_WIDTH-1:0] PRIME_COUNT = COUNT_WIDTH'(2);

  // microprogram step addresses
  typedef enum logic [2:0] {
    PC_WAIT,
    PC_TEST,
    PC_DIV,
    PC_TALLY,
    PC_OUT,
    PC_BACK
  } pc_t;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_TALLY,
    OP_WRITE_OUT
  } op_t;

  // jump conditions: jump to target when true, else fall through
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_IN_XFER,
    C_D_GT_N,
    C_BIT_MORE,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    logic  take_in;
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    logic load;
    op_t  op;
  } dp_ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic                   d_gt_n;
    logic                   bit_last;
    logic [COUNT_WIDTH-1:0] count;
  } dp_stat_t;

  // control store
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    unique case (pc)
      PC_WAIT:  w = '{take_in: 1'b1, op: OP_NONE,      cond: C_NO_IN_XFER, target: PC_WAIT};
      PC_TEST:  w = '{take_in: 1'b0, op: OP_DIV_INIT,  cond: C_D_GT_N,     target: PC_OUT};
      PC_DIV:   w = '{take_in: 1'b0, op: OP_DIV_STEP,  cond: C_BIT_MORE,   target: PC_DIV};
      PC_TALLY: w = '{take_in: 1'b0, op: OP_TALLY,     cond: C_ALWAYS,     target: PC_TEST};
      PC_OUT:   w = '{take_in: 1'b0, op: OP_WRITE_OUT, cond: C_OUT_FULL,   target: PC_OUT};
      PC_BACK:  w = '{take_in: 1'b0, op: OP_NONE,      cond: C_ALWAYS,     target: PC_WAIT};
      default:  w = '{take_in: 1'b0, op: OP_NONE,      cond: C_ALWAYS,     target: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/trial_division_prime_test.sv
// From the input transfer to out_valid, every candidate from 1 to n, where n is the tested
// number, costs one range test, NUM_WIDTH restoring division steps and one tally; the divisions
// all run on the single shared remainder unit, and a last range test with candidate n + 1 ends it.
// Throughput: one number at a time; after the result enters the output register the sequencer
// passes through its back step to its wait step, where the next transfer is taken. Reset (rst,
// synchronous) returns the sequencer to its wait step and clears out_valid.
`default_nettype none

module trial_division_prime_test (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [tdpt_pkg::IN_WIDTH-1:0]         n_value,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       is_prime,
  output logic [tdpt_pkg::COUNT_WIDTH-1:0]           divisor_count
);
  import tdpt_pkg::*;

  pc_t      pc;
  pc_t      pc_next;
  uword_t   uw;
  dp_ctrl_t ctrl;
  dp_stat_t stat;
  logic     in_xfer;
  logic     out_full;
  logic     jump;

  // fetch the current control word
  assign uw       = ucode(pc);
  assign in_stall = !uw.take_in;
  assign in_xfer  = in_valid && !in_stall;
  assign out_full = out_valid && out_stall;

  assign ctrl.load = in_xfer;
  assign ctrl.op   = uw.op;

  // jump condition and next step
  always_comb begin
    case (uw.cond)
      C_ALWAYS:     jump = 1'b1;
      C_NO_IN_XFER: jump = !in_xfer;
      C_D_GT_N:     jump = stat.d_gt_n;
      C_BIT_MORE:   jump = !stat.bit_last;
      C_OUT_FULL:   jump = out_full;
      default:      jump = 1'b1;
    endcase
    pc_next = jump ? uw.target : pc_t'(3'(pc + 3'd1));
  end

  // step counter and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= PC_WAIT;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (uw.op == OP_WRITE_OUT && !out_full) begin
        out_valid     <= 1'b1;
        is_prime      <= stat.count == PRIME_COUNT;
        divisor_count <= stat.count;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  tdpt_datapath u_datapath (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .n_in (NUM_WIDTH'(n_value)),
    .stat (stat)
  );

`ifndef SYNTHESIS
  // an input transfer always starts a candidate sweep
  a_xfer_to_test: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> pc == PC_TEST)
    else $error("input transfer did not start the sweep");

  // a prime flag always comes with a count of two
  a_prime_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_prime |-> divisor_count == PRIME_COUNT)
    else $error("prime flag without two divisors");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    pc == PC_OUT && out_full |=> pc == PC_OUT)
    else $error("sequencer left output step while result held");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/tdpt_datapath.sv
`default_nettype none

module tdpt_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tdpt_pkg::dp_ctrl_t                  ctrl,
  input  wire logic [tdpt_pkg::NUM_WIDTH-1:0]      n_in,
  output tdpt_pkg::dp_stat_t                       stat
);
  import tdpt_pkg::*;

  logic [NUM_WIDTH-1:0]   n_reg;
  logic [NUM_WIDTH:0]     d_reg;
  logic [NUM_WIDTH-1:0]   rem;
  logic [NUM_WIDTH-1:0]   rem_next;
  logic [NUM_WIDTH-1:0]   dividend;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [COUNT_WIDTH-1:0] count;

  logic [NUM_WIDTH:0]     rem_sh;
  logic [NUM_WIDTH:0]     rem_sub;
  logic                   rem_ge;

  // one restoring division step: shift in the next dividend bit
  always_comb begin
    rem_sh   = {rem, dividend[NUM_WIDTH-1]};
    rem_sub  = rem_sh - d_reg;
    rem_ge   = rem_sh >= d_reg;
    rem_next = rem_ge ? rem_sub[NUM_WIDTH-1:0] : rem_sh[NUM_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= '0;
      count   <= '0;
    end else begin
      // new number: first candidate is one
      if (ctrl.load) begin
        n_reg <= n_in;
        d_reg <= (NUM_WIDTH+1)'(1);
        count <= '0;
      end
      case (ctrl.op)
        OP_DIV_INIT: begin
          rem      <= '0;
          dividend <= n_reg;
          bit_cnt  <= '0;
        end
        OP_DIV_STEP: begin
          rem      <= rem_next;
          dividend <= {dividend[NUM_WIDTH-2:0], 1'b0};
          bit_cnt  <= bit_cnt + BIT_CNT_W'(1);
        end
        OP_TALLY: begin
          // saturating count of exact divisors
          if (rem == '0 && count != COUNT_MAX) begin
            count <= count + COUNT_WIDTH'(1);
          end
          d_reg <= d_reg + (NUM_WIDTH+1)'(1);
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.d_gt_n   = d_reg > {1'b0, n_reg};
  assign stat.bit_last = bit_cnt == BIT_CNT_W'(NUM_WIDTH - 1);
  assign stat.count    = count;

`ifndef SYNTHESIS
  // a division step runs only while a candidate is in range
  a_div_in_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_DIV_STEP |-> !stat.d_gt_n)
    else $error("division step with candidate beyond number");

  // the bit counter restarts at every division
  a_div_init: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_DIV_INIT |=> bit_cnt == '0)
    else $error("bit counter not cleared at division start");

  // the count holds outside a tally or a load; a tally moves it by at most one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    ctrl.op != OP_TALLY && !ctrl.load |=> $stable(count))
    else $error("count changed outside a tally");
`endif

endmodule

`default_nettype wire
